// File: rtl/cpf_pkg.sv
// Shared types, constants and CRC32C helpers for the CRC32C packet framer.
// Depends on nothing; the input stage, emitter and top refer to it by scoped names.
package cpf_pkg;

	// Input word operation codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// Castagnoli CRC, reflected form.
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Byte positions within one emitted run. Positions 0 to 11 carry the ID and
	// length, 12 to 15 the header CRC, and 16 to 19 the trailer.
	localparam int POS_W = 5;
	localparam logic [POS_W-1:0] POS_FIRST_FIELD = 5'd1;
	localparam logic [POS_W-1:0] POS_LAST_FIELD  = 5'd11;
	localparam logic [POS_W-1:0] POS_LAST_HCRC   = 5'd15;
	localparam logic [POS_W-1:0] POS_FIRST_TRL   = 5'd16;
	localparam logic [POS_W-1:0] POS_LAST_TRL    = 5'd19;

	// Index of the highest header field byte, counted from the least significant end.
	localparam logic [3:0] FIELD_TOP_IDX = 4'd11;

	// One accepted input word, as held in the input stage.
	typedef struct packed {
		logic        operation;
		logic [63:0] packet_id;
		logic [31:0] length;
		logic [7:0]  data_byte;
	} item_t;

	// Fold one byte into a running CRC32C register.
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Byte idx of a CRC word: big-endian when order is 0, little-endian when 1.
	function automatic logic [7:0] crc_byte(input logic [31:0] word, input logic [1:0] idx,
		input logic order);
		logic [1:0] sel;
		sel = order ? idx : (2'd3 - idx);
		return word[{sel, 3'b000} +: 8];
	endfunction

endpackage

// File: rtl/cpf_in_if.sv
// Input channel of the CRC32C packet framer: valid/ready handshake and payload.
// Depends on nothing.
interface cpf_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] packet_id;
	logic [31:0] length;
	logic [7:0]  data_byte;

	modport source(output valid, operation, packet_id, length, data_byte, input ready);
	modport sink(input valid, operation, packet_id, length, data_byte, output ready);
endinterface

// File: rtl/cpf_out_if.sv
// Output channel of the CRC32C packet framer: valid/ready handshake and payload.
// Depends on nothing.
interface cpf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       packet_end;
	logic       run_end;

	modport source(output valid, out_byte, packet_end, run_end, input ready);
	modport sink(input valid, out_byte, packet_end, run_end, output ready);
endinterface

// File: rtl/cpf_in_stage.sv
// Input register of the framer: holds one accepted word until the emitter takes it.
// Depends on cpf_pkg and cpf_in_if.
module cpf_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	cpf_in_if.sink          in_ch,
	output cpf_pkg::item_t  item,
	output logic            item_valid,
	input  logic            item_take
);

	logic           valid_s1;
	cpf_pkg::item_t item_s1;
	logic           accept;

	// The register frees up in the same cycle the emitter takes its word.
	assign in_ch.ready = !valid_s1 || item_take;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.operation <= in_ch.operation;
			item_s1.packet_id <= in_ch.packet_id;
			item_s1.length    <= in_ch.length;
			item_s1.data_byte <= in_ch.data_byte;
		end
	end

	assign item       = item_s1;
	assign item_valid = valid_s1;

endmodule

// File: rtl/cpf_emitter.sv
// Byte emitter of the framer: header, data and trailer sequencing, CRC state and
// the output register. Depends on cpf_pkg and cpf_out_if.
module cpf_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            crc_order,
	input  cpf_pkg::item_t  item,
	input  logic            item_valid,
	output logic            item_take,
	cpf_out_if.source       out_ch
);

	// Sequencer and packet state.
	logic                      busy_q, busy_n;
	logic [cpf_pkg::POS_W-1:0] pos_q, pos_n;
	logic [31:0]               hcrc_q, hcrc_n;
	logic [31:0]               dcrc_q, dcrc_n;
	logic [31:0]               left_q, left_n;
	logic                      open_q, open_n;
	logic [63:0]               id_q, id_n;
	logic [31:0]               len_q, len_n;

	// Output register.
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       opend_q;
	logic       orun_q;

	logic        adv;
	logic        emit;
	logic [7:0]  e_byte;
	logic        e_pend;
	logic        e_run;
	logic [95:0] hdr_word;
	logic [3:0]  hidx;
	logic [7:0]  hdr_sel;
	logic [31:0] hcrc_step;
	logic [31:0] trl_word;

	assign adv       = !ovalid_q || out_ch.ready;
	assign item_take = item_valid && !busy_q && adv;

	assign hdr_word  = {id_q, len_q};
	assign hidx      = cpf_pkg::FIELD_TOP_IDX - pos_q[3:0];
	assign hdr_sel   = hdr_word[{hidx, 3'b000} +: 8];
	assign hcrc_step = cpf_pkg::crc_feed(hcrc_q, hdr_sel);
	assign trl_word  = ~dcrc_q ^ hcrc_q;

	always_comb begin
		emit   = 1'b0;
		e_byte = 8'h00;
		e_pend = 1'b0;
		e_run  = 1'b0;
		busy_n = busy_q;
		pos_n  = pos_q;
		hcrc_n = hcrc_q;
		dcrc_n = dcrc_q;
		left_n = left_q;
		open_n = open_q;
		id_n   = id_q;
		len_n  = len_q;
		if (busy_q && adv) begin
			emit = 1'b1;
			priority if (pos_q <= cpf_pkg::POS_LAST_FIELD) begin
				// ID and length bytes; the header CRC runs along with them.
				e_byte = hdr_sel;
				hcrc_n = (pos_q == cpf_pkg::POS_LAST_FIELD) ? ~hcrc_step : hcrc_step;
				pos_n  = pos_q + 5'd1;
			end else if (pos_q <= cpf_pkg::POS_LAST_HCRC) begin
				e_byte = cpf_pkg::crc_byte(hcrc_q, pos_q[1:0], crc_order);
				if (pos_q == cpf_pkg::POS_LAST_HCRC) begin
					if (len_q == 32'd0) begin
						pos_n = cpf_pkg::POS_FIRST_TRL;
					end else begin
						e_run  = 1'b1;
						busy_n = 1'b0;
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end else begin
				e_byte = cpf_pkg::crc_byte(trl_word, pos_q[1:0], crc_order);
				if (pos_q == cpf_pkg::POS_LAST_TRL) begin
					e_pend = 1'b1;
					e_run  = 1'b1;
					busy_n = 1'b0;
					open_n = 1'b0;
					left_n = 32'd0;
					dcrc_n = cpf_pkg::CRC_INIT;
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
		end else if (item_take) begin
			if (item.operation == cpf_pkg::OP_START) begin
				// A start opens a new packet, dropping any open one.
				emit   = 1'b1;
				e_byte = item.packet_id[63:56];
				id_n   = item.packet_id;
				len_n  = item.length;
				hcrc_n = cpf_pkg::crc_feed(cpf_pkg::CRC_INIT, item.packet_id[63:56]);
				dcrc_n = cpf_pkg::CRC_INIT;
				left_n = item.length;
				open_n = (item.length != 32'd0);
				busy_n = 1'b1;
				pos_n  = cpf_pkg::POS_FIRST_FIELD;
			end else if (open_q) begin
				emit   = 1'b1;
				e_byte = item.data_byte;
				dcrc_n = cpf_pkg::crc_feed(dcrc_q, item.data_byte);
				left_n = left_q - 32'd1;
				if (left_q == 32'd1) begin
					busy_n = 1'b1;
					pos_n  = cpf_pkg::POS_FIRST_TRL;
				end else begin
					e_run = 1'b1;
				end
			end
			// A data word with no packet open is consumed and gives nothing.
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pos_q    <= '0;
			hcrc_q   <= 32'h0;
			dcrc_q   <= cpf_pkg::CRC_INIT;
			left_q   <= 32'd0;
			open_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			busy_q <= busy_n;
			pos_q  <= pos_n;
			hcrc_q <= hcrc_n;
			dcrc_q <= dcrc_n;
			left_q <= left_n;
			open_q <= open_n;
			if (adv) begin
				ovalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		id_q  <= id_n;
		len_q <= len_n;
		if (adv && emit) begin
			obyte_q <= e_byte;
			opend_q <= e_pend;
			orun_q  <= e_run;
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.out_byte   = obyte_q;
	assign out_ch.packet_end = opend_q;
	assign out_ch.run_end    = orun_q;

endmodule

// File: rtl/crc32c_packet_framer.sv
// Top level of the CRC32C packet framer: input register, byte emitter and the
// byte order register. Depends on cpf_pkg, cpf_in_if, cpf_out_if and the submodules.
//
//   channel   direction  handshake      carries
//   in_ch     in         valid/ready    operation, packet_id, length, data_byte
//   out_ch    out        valid/ready    out_byte, packet_end, run_end
//   cfg       in         cfg_we         cfg_wdata (CRC byte order)
//
// The framer puts out one byte per cycle. A data word gives one byte, or five when it
// closes its packet; a start word gives 16 bytes, or 20 for a zero-length packet. The
// rate is set by the single byte-wide output register and the emitter behind it.
// The input register takes the next word while the emitter still drains the current
// one, so a stream of data words moves at one word per cycle. A stall on out_ch holds
// the output register and, once the input register is full, backs up into in_ch.
// Reset clears the handshake, sequencer and CRC state; no packet is open after reset.
module crc32c_packet_framer (
	input  logic       clk,
	input  logic       arst_n,
	cpf_in_if.sink     in_ch,
	cpf_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	cpf_pkg::item_t item;
	logic           item_valid;
	logic           item_take;
	logic           order_q;

	// CRC byte order: 0 sends CRC words big-endian, 1 little-endian.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	// Input register: parts the input handshake from the emitter.
	cpf_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	// Emitter: header, data and trailer bytes, CRC state and output register.
	cpf_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.crc_order  (order_q),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.out_ch     (out_ch)
	);

endmodule
